[src/bsl2_pkg.sv]
// Shared types and constants for the squared byte distance block.
`default_nettype none

package bsl2_pkg;

    localparam int ITEM_LANES  = 16;
    localparam int BYTE_W      = 8;
    localparam int SQ_W        = 16;
    localparam int QUAD_W      = 18;
    localparam int CHUNK_W     = 20;
    localparam int SUM_W       = 28;
    localparam int COUNT_W     = 5;
    localparam longint unsigned LANE_SQ_MAX = 64'd65025;

    typedef logic [BYTE_W-1:0]  lane_byte_t;
    typedef logic [SQ_W-1:0]    lane_sq_t;
    typedef logic [QUAD_W-1:0]  quad_sum_t;
    typedef logic [CHUNK_W-1:0] chunk_sum_t;
    typedef logic [SUM_W-1:0]   dist_sum_t;

    typedef struct packed {
        logic valid;
        logic last;
    } stage_ctl_t;

    typedef struct packed {
        logic quad;
        logic total;
    } merge_en_t;

endpackage

`default_nettype wire

[src/bsl2_lane.sv]
// One lane: masked square of the absolute byte difference, registered.
`default_nettype none

module bsl2_lane (
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic                lane_on,
    input  wire bsl2_pkg::lane_byte_t x_byte,
    input  wire bsl2_pkg::lane_byte_t y_byte,
    output bsl2_pkg::lane_sq_t       sq_reg
);
    import bsl2_pkg::*;

    lane_byte_t diff;
    lane_sq_t   sq_next;

    always_comb
    begin
        diff    = (x_byte >= y_byte) ? (x_byte - y_byte) : (y_byte - x_byte);
        sq_next = lane_on ? (SQ_W'(diff) * SQ_W'(diff)) : '0;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg <= sq_next;
        end
    end

endmodule

`default_nettype wire

[src/bsl2_merge.sv]
// Two-level registered adder tree that merges the lane squares into one chunk sum.
`default_nettype none

module bsl2_merge #(
    parameter int N = 16
) (
    input  wire logic                        clk,
    input  wire bsl2_pkg::merge_en_t         en,
    input  wire bsl2_pkg::lane_sq_t [N-1:0]  sq,
    output bsl2_pkg::chunk_sum_t             chunk_reg
);
    import bsl2_pkg::*;

    localparam int GROUPS = (N + 3) / 4;

    quad_sum_t [GROUPS-1:0] quad_reg;
    quad_sum_t [GROUPS-1:0] quad_next;
    chunk_sum_t             chunk_next;

    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            quad_next[g] = '0;
            for (int k = 0; k < 4; k++)
            begin
                if (4 * g + k < N)
                begin
                    quad_next[g] = quad_next[g] + QUAD_W'(sq[4 * g + k]);
                end
            end
        end
    end

    always_comb
    begin
        chunk_next = '0;
        for (int g = 0; g < GROUPS; g++)
        begin
            chunk_next = chunk_next + CHUNK_W'(quad_reg[g]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.quad)
        begin
            quad_reg <= quad_next;
        end
        if (en.total)
        begin
            chunk_reg <= chunk_next;
        end
    end

endmodule

`default_nettype wire

[src/byte_squared_l2_distance.sv]
// A result is written to the output register after its last item passes the lane square, quad and chunk registers.
// Throughput: one item per cycle while item_stall is low; lanes square, a two-level tree merges, one adder accumulates.
// The accumulator add-and-saturate loop holds no pipeline register inside it, so items never wait on each other.
// A stalled result holds the output register while the three pipeline stages keep filling.
// Reset clears the stage valids, the output valid and the running sum to zero.
`default_nettype none

module byte_squared_l2_distance #(
    parameter int LANES   = 16,
    parameter int MAX_DIM = 4096
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic [63:0] x_bytes_low,
    input  wire logic [63:0] x_bytes_high,
    input  wire logic [63:0] y_bytes_low,
    input  wire logic [63:0] y_bytes_high,
    input  wire logic [4:0]  valid_lanes,
    input  wire logic        last,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [27:0]      distance_sum
);
    import bsl2_pkg::*;

    localparam int ACT_LANES = (LANES < ITEM_LANES) ? LANES : ITEM_LANES;
    localparam longint unsigned DIM_LIM = longint'(MAX_DIM) * LANE_SQ_MAX;
    localparam longint unsigned SUM_TOP = (64'd1 << SUM_W) - 64'd1;
    localparam dist_sum_t SUM_LIM = (DIM_LIM > SUM_TOP) ? SUM_W'(SUM_TOP) : SUM_W'(DIM_LIM);

    logic [2*ITEM_LANES*BYTE_W/2-1:0] x_all;
    logic [2*ITEM_LANES*BYTE_W/2-1:0] y_all;

    stage_ctl_t s1_reg, s2_reg, s3_reg;
    logic       out_ready, take3, rdy1, rdy2, rdy3;
    merge_en_t  merge_en;

    lane_sq_t [ACT_LANES-1:0] sq;
    chunk_sum_t               chunk;

    dist_sum_t           acc_reg, acc_next;
    logic [SUM_W:0]      acc_add;
    dist_sum_t           acc_sat;
    logic                res_valid_reg, res_valid_next;
    dist_sum_t           res_sum_reg;

    assign x_all = {x_bytes_high, x_bytes_low};
    assign y_all = {y_bytes_high, y_bytes_low};

    assign out_ready  = !res_valid_reg || !result_stall;
    assign take3      = s3_reg.valid && (!s3_reg.last || out_ready);
    assign rdy3       = !s3_reg.valid || take3;
    assign rdy2       = !s2_reg.valid || rdy3;
    assign rdy1       = !s1_reg.valid || rdy2;
    assign item_stall = !rdy1;

    assign merge_en.quad  = rdy2;
    assign merge_en.total = rdy3;

    for (genvar n = 0; n < ACT_LANES; n++)
    begin : g_lane
        bsl2_lane u_lane (
            .clk     (clk),
            .en      (rdy1),
            .lane_on (COUNT_W'(n) < valid_lanes),
            .x_byte  (x_all[BYTE_W*n +: BYTE_W]),
            .y_byte  (y_all[BYTE_W*n +: BYTE_W]),
            .sq_reg  (sq[n])
        );
    end

    bsl2_merge #(
        .N (ACT_LANES)
    ) u_merge (
        .clk       (clk),
        .en        (merge_en),
        .sq        (sq),
        .chunk_reg (chunk)
    );

    always_comb
    begin
        acc_add = {1'b0, acc_reg} + (SUM_W + 1)'(chunk);
        acc_sat = (acc_add > {1'b0, SUM_LIM}) ? SUM_LIM : acc_add[SUM_W-1:0];

        acc_next = acc_reg;
        if (take3)
        begin
            acc_next = s3_reg.last ? '0 : acc_sat;
        end

        res_valid_next = res_valid_reg;
        if (take3 && s3_reg.last)
        begin
            res_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            s3_reg        <= '0;
            acc_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_reg.valid <= item_valid;
                s1_reg.last  <= last;
            end
            if (rdy2)
            begin
                s2_reg <= s1_reg;
            end
            if (rdy3)
            begin
                s3_reg <= s2_reg;
            end
            acc_reg       <= acc_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take3 && s3_reg.last)
        begin
            res_sum_reg <= acc_sat;
        end
    end

    assign result_valid = res_valid_reg;
    assign distance_sum = res_sum_reg;

endmodule

`default_nettype wire
